### rtl/core/rspe_pkg.sv
// shared types, constants and GF(256) helpers for the reed-solomon parity encoder
// no dependencies; used by rspe_cell and reed_solomon_parity_encoder
package rspe_pkg;

    localparam int MAX_PARITY_BYTES = 30;
    localparam int RESULT_LIMIT     = 30;
    localparam int COUNT_LIMIT      = (MAX_PARITY_BYTES < RESULT_LIMIT) ?
                                      MAX_PARITY_BYTES : RESULT_LIMIT;
    localparam int CNT_W            = $clog2(COUNT_LIMIT + 1);
    localparam int EC_W             = 5;
    localparam logic [EC_W-1:0] EC_RESET   = 5'd10;
    localparam logic [8:0]      FIELD_POLY = 9'h11D;

    typedef struct packed {
        logic step;   // a message word is accepted
        logic load;   // accepted word is the last one: move remainder to parity row
        logic shift;  // parity row moves one place toward the output
        logic clear;  // configuration write: drop remainder and generator
        logic build;  // one generator build iteration
    } t_cell_ctl;

    // multiply by alpha
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [8:0] x;
        x = {a, 1'b0};
        if (x[8]) begin
            x = x ^ FIELD_POLY;
        end
        return x[7:0];
    endfunction

    // shift-and-add multiply, eight narrow steps
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

    // effective parity count: zero acts as one, large values saturate
    function automatic logic [CNT_W-1:0] active_count(input logic [EC_W-1:0] ec);
        logic [CNT_W-1:0] n;
        if (ec == '0) begin
            n = CNT_W'(1);
        end else if (int'(ec) > COUNT_LIMIT) begin
            n = CNT_W'(COUNT_LIMIT);
        end else begin
            n = CNT_W'(ec);
        end
        return n;
    endfunction

endpackage

### rtl/core/reed_solomon_parity_encoder.sv
// systematic reed-solomon parity encoder over GF(256), field polynomial 0x11D
// top level; depends on rspe_pkg and rspe_cell
//
// usage:
//   s_axis carries message words, highest degree first; tlast marks the last
//   word of a message. m_axis returns the parity words of that message,
//   highest degree first, with tlast on the final parity word.
//   i_cfg_we / i_cfg_data write the parity count (0 acts as 1, above 30 as 30).
// throughput: one message word per cycle while s_axis_tready is high. each cell
//   of the row holds one remainder byte and updates it from the shared feedback byte.
// output: the first parity word is valid in the cycle after the last message
//   word is taken; the n parity words then leave one per cycle while m_axis_tready is high.
// the parity row is separate from the remainder row, so the next message is
//   taken while parity drains. a last word is held off, beyond the build, only while
//   the parity row still has more than one word to give, or one that is not taken now.
// receiver stall: parity words hold on m_axis; non-last words keep flowing.
// reset and configuration: the remainder clears and the generator is rebuilt
//   for the parity count (10 after reset), one root per cycle through the cell row;
//   s_axis_tready stays low during the build.
module reed_solomon_parity_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,      // parity count
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,    // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] parity_byte
    output logic       m_axis_tlast     // is_last_parity
);

    localparam int N = rspe_pkg::MAX_PARITY_BYTES;
    localparam int W = rspe_pkg::CNT_W;

    logic [rspe_pkg::EC_W-1:0] r_ec;
    logic [W-1:0]              r_out_cnt;   // parity words still to deliver
    logic [W-1:0]              n_out_cnt;
    logic [W-1:0]              r_bld_cnt;   // generator build iterations left
    logic [W-1:0]              n_bld_cnt;
    logic [7:0]                r_root;
    logic [7:0]                n_root;
    logic [W-1:0]              cnt_now;

    logic                building;
    logic                out_free;
    logic                out_shift;
    logic                in_step;
    logic [7:0]          fb;
    rspe_pkg::t_cell_ctl ctl;

    logic [7:0] rem_q [N];
    logic [7:0] gen_q [N];
    logic [7:0] par_q [N];

    assign building = (r_bld_cnt != '0);
    assign cnt_now  = rspe_pkg::active_count(r_ec);

    // output side
    assign m_axis_tvalid = (r_out_cnt != '0);
    assign m_axis_tlast  = (r_out_cnt == W'(1));
    assign m_axis_tdata  = par_q[0];
    assign out_shift     = m_axis_tvalid & m_axis_tready;

    // parity row can take a new block once it is empty or emptying now
    assign out_free = (r_out_cnt == '0) || ((r_out_cnt == W'(1)) && m_axis_tready);

    assign s_axis_tready = !building && (!s_axis_tlast || out_free);
    assign in_step       = s_axis_tvalid & s_axis_tready;

    // lfsr feedback
    assign fb = s_axis_tdata ^ rem_q[0];

    always_comb begin
        ctl.step  = in_step;
        ctl.load  = in_step & s_axis_tlast;
        ctl.shift = out_shift;
        ctl.clear = i_cfg_we;
        ctl.build = building & ~i_cfg_we;
    end

    always_comb begin
        n_out_cnt = r_out_cnt;
        if (ctl.load) begin
            n_out_cnt = cnt_now;
        end else if (out_shift) begin
            n_out_cnt = r_out_cnt - W'(1);
        end
    end

    always_comb begin
        n_bld_cnt = r_bld_cnt;
        n_root    = r_root;
        if (i_cfg_we) begin
            n_bld_cnt = rspe_pkg::active_count(i_cfg_data);
            n_root    = 8'h01;
        end else if (building) begin
            n_bld_cnt = r_bld_cnt - W'(1);
            n_root    = rspe_pkg::gf_xtime(r_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec      <= rspe_pkg::EC_RESET;
            r_out_cnt <= '0;
            r_bld_cnt <= rspe_pkg::active_count(rspe_pkg::EC_RESET);
            r_root    <= 8'h01;
        end else begin
            if (i_cfg_we) begin
                r_ec <= i_cfg_data;
            end
            r_out_cnt <= n_out_cnt;
            r_bld_cnt <= n_bld_cnt;
            r_root    <= n_root;
        end
    end

    // cell row: remainder and parity move toward cell 0, generator build
    // takes the coefficient from the cell below (an implicit leading 1)
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [7:0] rem_next;
        logic [7:0] gen_prev;
        logic [7:0] par_next;

        if (i == N - 1) begin : g_top
            assign rem_next = 8'h00;
            assign par_next = 8'h00;
        end else begin : g_mid
            assign rem_next = rem_q[i+1];
            assign par_next = par_q[i+1];
        end

        if (i == 0) begin : g_lead
            assign gen_prev = 8'h01;
        end else begin : g_rest
            assign gen_prev = gen_q[i-1];
        end

        rspe_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_fb       (fb),
            .i_root     (r_root),
            .i_rem_next (rem_next),
            .i_gen_prev (gen_prev),
            .i_par_next (par_next),
            .o_rem      (rem_q[i]),
            .o_gen      (gen_q[i]),
            .o_par      (par_q[i])
        );
    end

endmodule

### rtl/core/rspe_cell.sv
// one cell of the encoder row: remainder byte, generator coefficient, parity byte
// depends on rspe_pkg (t_cell_ctl, gf_mul)
module rspe_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rspe_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_fb,        // feedback byte, shared by all cells
    input  logic [7:0]         i_root,      // current root during generator build
    input  logic [7:0]         i_rem_next,  // remainder of the next higher cell
    input  logic [7:0]         i_gen_prev,  // coefficient of the previous cell
    input  logic [7:0]         i_par_next,  // parity byte of the next higher cell
    output logic [7:0]         o_rem,
    output logic [7:0]         o_gen,
    output logic [7:0]         o_par
);

    logic [7:0] r_rem;
    logic [7:0] r_gen;
    logic [7:0] r_par;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] prod;
    logic [7:0] n_rem;

    // one multiplier serves both the lfsr update and the generator build
    assign mul_a = i_ctl.build ? i_gen_prev : r_gen;
    assign mul_b = i_ctl.build ? i_root     : i_fb;
    assign prod  = rspe_pkg::gf_mul(mul_a, mul_b);
    assign n_rem = i_rem_next ^ prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 8'h00;
            r_gen <= 8'h00;
        end else if (i_ctl.clear) begin
            r_rem <= 8'h00;
            r_gen <= 8'h00;
        end else begin
            if (i_ctl.build) begin
                r_gen <= r_gen ^ prod;
            end
            if (i_ctl.step) begin
                r_rem <= i_ctl.load ? 8'h00 : n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_par <= n_rem;
        end else if (i_ctl.shift) begin
            r_par <= i_par_next;
        end
    end

    assign o_rem = r_rem;
    assign o_gen = r_gen;
    assign o_par = r_par;

endmodule

### tb/rspe_checker.sv
// parity checker for the reed-solomon parity encoder: watches config, message and parity streams
// keeps its own LFSR remainder and generator taps; depends on rspe_pkg for sizes and field polynomial
module rspe_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rspe_pkg::EC_W-1:0] i_cfg_data,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [7:0]                i_s_tdata,
    input  logic                      i_s_tlast,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [7:0]                i_m_tdata,
    input  logic                      i_m_tlast,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       is_last_parity;
    } t_parity_word;

    t_parity_word              expected_parity[$];
    logic [rspe_pkg::EC_W-1:0] parity_count_q;
    logic [7:0]                lfsr_bytes [rspe_pkg::MAX_PARITY_BYTES];
    logic [7:0]                gen_taps   [rspe_pkg::MAX_PARITY_BYTES];
    int                        mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // carry-less product, then fold the high bits back with the field polynomial
    function automatic logic [7:0] gf256_product(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] wide;
        wide = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                wide = wide ^ (15'(a) << i);
            end
        end
        for (int i = 14; i >= 8; i--) begin
            if (wide[i]) begin
                wide = wide ^ (15'(rspe_pkg::FIELD_POLY) << (i - 8));
            end
        end
        return wide[7:0];
    endfunction

    function automatic int parity_len(input logic [rspe_pkg::EC_W-1:0] ec);
        if (ec == '0) begin
            return 1;
        end
        if (int'(ec) > rspe_pkg::COUNT_LIMIT) begin
            return rspe_pkg::COUNT_LIMIT;
        end
        return int'(ec);
    endfunction

    // new count: product of (x + alpha^i), remainder dropped
    task automatic load_parity_count(input logic [rspe_pkg::EC_W-1:0] ec);
        logic [7:0] poly [rspe_pkg::MAX_PARITY_BYTES + 1];
        logic [7:0] root;
        int         n;
        parity_count_q = ec;
        n    = parity_len(ec);
        root = 8'h01;
        foreach (poly[j]) begin
            poly[j] = 8'h00;
        end
        poly[0] = 8'h01;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j >= 1; j--) begin
                poly[j] = poly[j] ^ gf256_product(poly[j - 1], root);
            end
            root = gf256_product(root, 8'h02);
        end
        for (int i = 0; i < rspe_pkg::MAX_PARITY_BYTES; i++) begin
            gen_taps[i]   = (i < n) ? poly[i + 1] : 8'h00;
            lfsr_bytes[i] = 8'h00;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic last);
        t_parity_word w;
        logic [7:0]   fb;
        int           n;
        n  = parity_len(parity_count_q);
        fb = data ^ lfsr_bytes[0];
        for (int i = 0; i < n - 1; i++) begin
            lfsr_bytes[i] = lfsr_bytes[i + 1] ^ gf256_product(gen_taps[i], fb);
        end
        lfsr_bytes[n - 1] = gf256_product(gen_taps[n - 1], fb);
        if (last) begin
            for (int i = 0; i < n; i++) begin
                w.parity_byte    = lfsr_bytes[i];
                w.is_last_parity = (i == n - 1);
                expected_parity.push_back(w);
                lfsr_bytes[i] = 8'h00;
            end
        end
    endtask

    task automatic check_parity_word();
        t_parity_word w;
        if (expected_parity.size() == 0) begin
            $error("unexpected parity word: parity_byte %02h is_last_parity %0b",
                   i_m_tdata, i_m_tlast);
            mismatch_count++;
        end else begin
            w = expected_parity.pop_front();
            if (i_m_tdata !== w.parity_byte) begin
                $error("parity_byte mismatch: expected %02h, actual %02h",
                       w.parity_byte, i_m_tdata);
                mismatch_count++;
            end
            if (i_m_tlast !== w.is_last_parity) begin
                $error("is_last_parity mismatch: expected %0b, actual %0b",
                       w.is_last_parity, i_m_tlast);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_parity_count(rspe_pkg::EC_RESET);
        end else begin
            if (i_cfg_we) begin
                load_parity_count(i_cfg_data);
            end
            // compare before predicting so a new message never masks a stray word
            if (i_m_tvalid && i_m_tready) begin
                check_parity_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= expected_parity.size();
    end

endmodule

### tb/tb_top.sv
// top of the reed-solomon parity encoder bench: clock, reset, message stimulus and verdict
// depends on rspe_pkg, reed_solomon_parity_encoder and rspe_checker
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;     // last word to idle, with margin
    localparam int HOLD_CYCLES   = 400;   // long receiver stall

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [rspe_pkg::EC_W-1:0] i_cfg_data    = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = 8'h00;
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;
    logic                      m_axis_tlast;

    int   fail_count;
    int   pending_words;
    int   tx_idle_pct = 22;
    int   rx_idle_pct = 65;
    logic hold_off    = 1'b0;
    logic hold_go     = 1'b0;
    int   cycle_count = 0;

    reed_solomon_parity_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rspe_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL reed_solomon_parity_encoder");
            $finish;
        end
    end

    // receiver: random back-pressure, forced low during the long hold
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // long stall counted here while the sender keeps offering words
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // one message word; called at a clock edge, returns at the edge that takes it
    task automatic send_word(input logic [7:0] data, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // only with no parity owed; the block rebuilds its generator before taking words
    task automatic write_parity_count(input logic [rspe_pkg::EC_W-1:0] ec);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ec;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // extremes show up often so every data bit sees both values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int         sent;
        int         len;
        logic [4:0] ec;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of 10: zero message gives zero parity
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b1);
        // zero count acts as one
        write_parity_count(5'd0);
        send_word(8'hFF, 1'b1);
        // above the limit saturates to thirty
        write_parity_count(5'd31);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        write_parity_count(5'd30);
        send_word(8'h01, 1'b1);
        // a write mid-message drops the partial remainder
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        write_parity_count(5'd1);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b1);
        // one-word messages back to back, next message taken while parity drains
        write_parity_count(5'd5);
        send_word(8'hA5, 1'b1);
        send_word(8'h5A, 1'b1);
        send_word(8'h00, 1'b1);

        // random messages: two count settings per idling mode
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 22 : 0;
            for (int part = 0; part < 2; part++) begin
                ec = (phase == 0 && part == 1) ? 5'd30 :
                     (phase == 1 && part == 1) ? 5'd1  : 5'($urandom_range(31));
                write_parity_count(ec);
                if (phase == 2 && part == 0) begin
                    hold_go = 1'b1;
                end
                sent = 0;
                while (sent < 65) begin
                    len = ($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 40);
                    for (int k = 0; k < len; k++) begin
                        send_word(pick_byte(), k == len - 1);
                    end
                    sent += len;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS reed_solomon_parity_encoder");
        end else begin
            $display("FAIL reed_solomon_parity_encoder");
        end
        $finish;
    end

endmodule
